// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package htw_pkg;

	// slot count per wheel is a power of two: slot index is {level, position}
	localparam int SLOTS_PER_WHEEL = 64;
	localparam int NUM_WHEELS      = 4;
	localparam int NUM_TIMERS      = 64;

	localparam int SLOT_W    = $clog2(SLOTS_PER_WHEEL);
	localparam int LVL_W     = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	localparam int TID_W     = $clog2(NUM_TIMERS);
	localparam int NXT_W     = TID_W + 1;
	localparam int SIDX_W    = LVL_W + SLOT_W;
	localparam int NUM_SLOTS = NUM_WHEELS * SLOTS_PER_WHEEL;
	localparam int ID_W      = 6;
	localparam int DELAY_W   = 32;
	localparam int REM_W     = SLOT_W * NUM_WHEELS;

	localparam logic [NXT_W-1:0] NIL = NXT_W'(NUM_TIMERS);

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED  = 2'd0,
		KIND_ADDED    = 2'd1,
		KIND_REJECTED = 2'd2,
		KIND_NO_EXP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OID_PID  = 2'd0,
		OID_CUR  = 2'd1,
		OID_ZERO = 2'd2
	} oid_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_CHK,
		ST_A_WR,
		ST_A_OK,
		ST_A_REJ,
		ST_T_HEAD,
		ST_T_EMPTY,
		ST_T_LOAD,
		ST_W_RD,
		ST_W_OUT,
		ST_ADV,
		ST_C_HEAD,
		ST_C_LOAD,
		ST_C_RD,
		ST_C_SET,
		ST_C_CHK,
		ST_C_WR
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     pl_check;
		logic     pl_commit;
		logic     pl_link;
		logic     head_take;
		logic     cur_from_head;
		logic     walk_rd;
		logic     walk_expire;
		logic     cur_from_next;
		logic     cas_set;
		logic     out_load;
		kind_t    out_kind;
		oid_sel_t out_id_sel;
		logic     out_last_nxt;
		logic     adv_inc;
		logic     adv_wrap;
		logic     lvl_up;
	} cmd_t;

	typedef struct packed {
		logic id_ok;
		logic armed_hit;
		logic pl_ok;
		logic head_hit;
		logic nxt_nil;
		logic cur_nil;
		logic wrap;
		logic lvl_top;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/hierarchical_timer_wheel.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Multi-level timing wheel over a fixed timer pool: add requests place a timer
// by delay, tick requests expire the current level-0 slot and cascade on wrap.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   opcode, timer_id, delay_ticks
//   out      out_valid / out_stall kind, expired_id, last
//
// One request at a time. Add: check, write, answer; a rejected add skips the
// write. Tick: take the slot head and answer no-expiry if empty, else read and
// output each expired timer; then advance, and per wrap take the next level's
// current slot and move its timers down one at a time (read, set, check, write).
// Slot heads carry valid bits cleared by reset; no clearing pass.
// A stalled result holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hierarchical_timer_wheel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [htw_pkg::ID_W-1:0]     timer_id,
	input  logic [htw_pkg::DELAY_W-1:0]  delay_ticks,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   kind,
	output logic [htw_pkg::ID_W-1:0]     expired_id,
	output logic                         last
);

	htw_pkg::cmd_t cmd;
	htw_pkg::sts_t sts;

	htw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	htw_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_id      (timer_id),
		.in_delay   (delay_ticks),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.expired_id (expired_id),
		.last       (last)
	);

	`ASSERT_IMPLY(a_out_load_free, clk, arst_n, cmd.out_load, sts.out_free)
	`ASSERT_IMPLY(a_commit_in_range, clk, arst_n, cmd.pl_commit, sts.pl_ok)
	`ASSERT_IMPLY(a_take_valid_head, clk, arst_n, cmd.head_take, sts.head_hit)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

// File: rtl/core/htw_datapath.sv
// ----------------------------------------------------------------------------
// htw_datapath
// Slot lists, timer links and remainders, wheel positions, placement logic
// and the result register.
// ----------------------------------------------------------------------------
module htw_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [htw_pkg::ID_W-1:0]     in_id,
	input  logic [htw_pkg::DELAY_W-1:0]  in_delay,
	input  htw_pkg::cmd_t                cmd,
	output htw_pkg::sts_t                sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   kind,
	output logic [htw_pkg::ID_W-1:0]     expired_id,
	output logic                         last
);

	logic [htw_pkg::NXT_W-1:0]   next_mem_x [htw_pkg::NUM_TIMERS];
	logic [htw_pkg::REM_W-1:0]   rem_mem  [htw_pkg::NUM_TIMERS];
	logic [htw_pkg::TID_W-1:0]   head_mem [htw_pkg::NUM_SLOTS];
	logic [htw_pkg::TID_W-1:0]   tail_mem [htw_pkg::NUM_SLOTS];

	logic [htw_pkg::NUM_TIMERS-1:0] armed_q;
	logic [htw_pkg::NUM_SLOTS-1:0]  hvld_q;
	logic [htw_pkg::SLOT_W-1:0]     wp_q [htw_pkg::NUM_WHEELS];
	logic [htw_pkg::LVL_W-1:0]      lvl_q;

	logic [htw_pkg::ID_W-1:0]    pid_q;
	logic [htw_pkg::DELAY_W-1:0] pv_q;
	logic [htw_pkg::NXT_W-1:0]   cur_q;
	logic [htw_pkg::SIDX_W-1:0]  slot_q;
	logic [htw_pkg::NXT_W-1:0]   next_rd_q;
	logic [htw_pkg::REM_W-1:0]   rem_rd_q;
	logic [htw_pkg::TID_W-1:0]   head_rd_q;
	logic [htw_pkg::TID_W-1:0]   tail_rd_q;

	logic                        out_v_q;
	htw_pkg::kind_t              kind_q;
	logic [htw_pkg::ID_W-1:0]    oid_q;
	logic                        last_q;

	logic                        pl_ok;
	logic [htw_pkg::LVL_W-1:0]   pl_lvl;
	logic [htw_pkg::SLOT_W-1:0]  pl_pos;
	logic [htw_pkg::REM_W-1:0]   pl_rem;
	logic [htw_pkg::SIDX_W-1:0]  pl_slot;
	logic [htw_pkg::SIDX_W-1:0]  hd_slot;
	logic [htw_pkg::TID_W-1:0]   pidx;
	logic [htw_pkg::TID_W-1:0]   cidx;
	logic                        nxt_nil;
	logic                        out_free;

	// lowest level whose full span covers the value; later (lower) k wins
	always_comb begin
		pl_ok  = 1'b0;
		pl_lvl = '0;
		pl_pos = '0;
		pl_rem = '0;
		for (int k = htw_pkg::NUM_WHEELS - 1; k >= 0; k--) begin
			if ((64'(pv_q) >> (htw_pkg::SLOT_W * (k + 1))) == 64'd0) begin
				pl_ok  = 1'b1;
				pl_lvl = htw_pkg::LVL_W'(k);
				pl_pos = wp_q[k] + htw_pkg::SLOT_W'(64'(pv_q) >> (htw_pkg::SLOT_W * k));
				pl_rem = htw_pkg::REM_W'(64'(pv_q) &
					((64'd1 << (htw_pkg::SLOT_W * k)) - 64'd1));
			end
		end
	end

	assign pl_slot  = {pl_lvl, pl_pos};
	assign hd_slot  = {lvl_q, wp_q[lvl_q]};
	assign pidx     = pid_q[htw_pkg::TID_W-1:0];
	assign cidx     = cur_q[htw_pkg::TID_W-1:0];
	assign nxt_nil  = (next_rd_q == htw_pkg::NIL);
	assign out_free = !out_v_q || !out_stall;

	always_comb begin
		sts.id_ok     = ({1'b0, pid_q} < (htw_pkg::ID_W + 1)'(htw_pkg::NUM_TIMERS));
		sts.armed_hit = armed_q[pidx];
		sts.pl_ok     = pl_ok;
		sts.head_hit  = hvld_q[hd_slot];
		sts.nxt_nil   = nxt_nil;
		sts.cur_nil   = (cur_q == htw_pkg::NIL);
		sts.wrap      = (wp_q[lvl_q] == htw_pkg::SLOT_W'(htw_pkg::SLOTS_PER_WHEEL - 1));
		sts.lvl_top   = (lvl_q == htw_pkg::LVL_W'(htw_pkg::NUM_WHEELS - 1));
		sts.out_free  = out_free;
	end

	// memories: registered reads, one write per array per cycle
	always_ff @(posedge clk) begin
		if (cmd.pl_check) begin
			tail_rd_q <= tail_mem[pl_slot];
		end
		if (cmd.head_take) begin
			head_rd_q <= head_mem[hd_slot];
		end
		if (cmd.walk_rd) begin
			next_rd_q <= next_mem_x[cidx];
			rem_rd_q  <= rem_mem[cidx];
		end
		if (cmd.pl_commit) begin
			rem_mem[pidx]    <= pl_rem;
			next_mem_x[pidx] <= htw_pkg::NIL;
		end else if (cmd.pl_link && hvld_q[slot_q]) begin
			next_mem_x[tail_rd_q] <= {1'b0, pidx};
		end
		if (cmd.pl_link) begin
			tail_mem[slot_q] <= pidx;
			if (!hvld_q[slot_q]) begin
				head_mem[slot_q] <= pidx;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			hvld_q  <= '0;
			lvl_q   <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < htw_pkg::NUM_WHEELS; i++) begin
				wp_q[i] <= '0;
			end
		end else begin
			if (cmd.pl_commit) begin
				armed_q[pidx] <= 1'b1;
			end else if (cmd.walk_rd && cmd.walk_expire) begin
				armed_q[cidx] <= 1'b0;
			end
			if (cmd.pl_link) begin
				hvld_q[slot_q] <= 1'b1;
			end else if (cmd.head_take) begin
				hvld_q[hd_slot] <= 1'b0;
			end
			if (cmd.load_in) begin
				lvl_q <= '0;
			end else if (cmd.lvl_up) begin
				lvl_q <= lvl_q + 1'b1;
			end
			if (cmd.adv_inc) begin
				wp_q[lvl_q] <= wp_q[lvl_q] + 1'b1;
			end else if (cmd.adv_wrap) begin
				wp_q[lvl_q] <= '0;
			end
			if (cmd.out_load) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pid_q <= in_id;
			pv_q  <= in_delay;
		end else if (cmd.cas_set) begin
			pid_q <= htw_pkg::ID_W'(cidx);
			pv_q  <= htw_pkg::DELAY_W'(rem_rd_q);
		end
		if (cmd.cur_from_head) begin
			cur_q <= {1'b0, head_rd_q};
		end else if (cmd.cur_from_next) begin
			cur_q <= next_rd_q;
		end
		if (cmd.pl_check) begin
			slot_q <= pl_slot;
		end
		if (cmd.out_load) begin
			kind_q <= cmd.out_kind;
			last_q <= cmd.out_last_nxt ? nxt_nil : 1'b1;
			case (cmd.out_id_sel)
				htw_pkg::OID_PID: begin
					oid_q <= pid_q;
				end
				htw_pkg::OID_CUR: begin
					oid_q <= htw_pkg::ID_W'(cidx);
				end
				default: begin
					oid_q <= '0;
				end
			endcase
		end
	end

	assign out_valid  = out_v_q;
	assign kind       = kind_q;
	assign expired_id = oid_q;
	assign last       = last_q;

endmodule

// File: rtl/core/htw_ctrl.sv
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer for add, expiry walk, wheel advance and cascade.
// ----------------------------------------------------------------------------
module htw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           opcode,
	input  htw_pkg::sts_t  sts,
	output htw_pkg::cmd_t  cmd
);

	htw_pkg::state_t state_q;
	htw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != htw_pkg::ST_IDLE);

	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.out_kind     = htw_pkg::KIND_EXPIRED;
		cmd.out_id_sel   = htw_pkg::OID_PID;
		case (state_q)
			htw_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = (opcode == htw_pkg::OP_ADD) ? htw_pkg::ST_A_CHK
						: htw_pkg::ST_T_HEAD;
				end
			end
			htw_pkg::ST_A_CHK: begin
				cmd.pl_check = 1'b1;
				if (sts.id_ok && !sts.armed_hit && sts.pl_ok) begin
					cmd.pl_commit = 1'b1;
					state_d = htw_pkg::ST_A_WR;
				end else begin
					state_d = htw_pkg::ST_A_REJ;
				end
			end
			htw_pkg::ST_A_WR: begin
				cmd.pl_link = 1'b1;
				state_d = htw_pkg::ST_A_OK;
			end
			htw_pkg::ST_A_OK: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = htw_pkg::KIND_ADDED;
					state_d = htw_pkg::ST_IDLE;
				end
			end
			htw_pkg::ST_A_REJ: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = htw_pkg::KIND_REJECTED;
					state_d = htw_pkg::ST_IDLE;
				end
			end
			htw_pkg::ST_T_HEAD: begin
				if (sts.head_hit) begin
					cmd.head_take = 1'b1;
					state_d = htw_pkg::ST_T_LOAD;
				end else begin
					state_d = htw_pkg::ST_T_EMPTY;
				end
			end
			htw_pkg::ST_T_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_kind   = htw_pkg::KIND_NO_EXP;
					cmd.out_id_sel = htw_pkg::OID_ZERO;
					state_d = htw_pkg::ST_ADV;
				end
			end
			htw_pkg::ST_T_LOAD: begin
				cmd.cur_from_head = 1'b1;
				state_d = htw_pkg::ST_W_RD;
			end
			htw_pkg::ST_W_RD: begin
				cmd.walk_rd     = 1'b1;
				cmd.walk_expire = 1'b1;
				state_d = htw_pkg::ST_W_OUT;
			end
			htw_pkg::ST_W_OUT: begin
				if (sts.out_free) begin
					cmd.out_load      = 1'b1;
					cmd.out_kind      = htw_pkg::KIND_EXPIRED;
					cmd.out_id_sel    = htw_pkg::OID_CUR;
					cmd.out_last_nxt  = 1'b1;
					cmd.cur_from_next = 1'b1;
					state_d = sts.nxt_nil ? htw_pkg::ST_ADV : htw_pkg::ST_W_RD;
				end
			end
			htw_pkg::ST_ADV: begin
				if (!sts.wrap) begin
					cmd.adv_inc = 1'b1;
					state_d = htw_pkg::ST_IDLE;
				end else begin
					cmd.adv_wrap = 1'b1;
					if (sts.lvl_top) begin
						state_d = htw_pkg::ST_IDLE;
					end else begin
						cmd.lvl_up = 1'b1;
						state_d = htw_pkg::ST_C_HEAD;
					end
				end
			end
			htw_pkg::ST_C_HEAD: begin
				if (sts.head_hit) begin
					cmd.head_take = 1'b1;
					state_d = htw_pkg::ST_C_LOAD;
				end else begin
					state_d = htw_pkg::ST_ADV;
				end
			end
			htw_pkg::ST_C_LOAD: begin
				cmd.cur_from_head = 1'b1;
				state_d = htw_pkg::ST_C_RD;
			end
			htw_pkg::ST_C_RD: begin
				cmd.walk_rd = 1'b1;
				state_d = htw_pkg::ST_C_SET;
			end
			htw_pkg::ST_C_SET: begin
				// timer moves to placement, cursor steps to its successor
				cmd.cas_set       = 1'b1;
				cmd.cur_from_next = 1'b1;
				state_d = htw_pkg::ST_C_CHK;
			end
			htw_pkg::ST_C_CHK: begin
				cmd.pl_check  = 1'b1;
				cmd.pl_commit = 1'b1;
				state_d = htw_pkg::ST_C_WR;
			end
			htw_pkg::ST_C_WR: begin
				cmd.pl_link = 1'b1;
				state_d = sts.cur_nil ? htw_pkg::ST_ADV : htw_pkg::ST_C_RD;
			end
			default: begin
				state_d = htw_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: tb/hierarchical_timer_wheel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_test
// Drives add and tick requests into the timer wheel with random idling on
// both channels and checks every result against a wheel predictor.
// ----------------------------------------------------------------------------

class wheel_scoreboard;
	typedef struct {
		htw_pkg::kind_t kind;
		logic [5:0]     id;
		logic           last;
	} expiry_t;

	localparam int NTMR = htw_pkg::NUM_TIMERS;
	localparam int NSLT = htw_pkg::SLOTS_PER_WHEEL;
	localparam int NWHL = htw_pkg::NUM_WHEELS;

	expiry_t expiries[$];
	int      errors;
	int      link[NTMR];
	longint  remain[NTMR];
	bit      armed[NTMR];
	int      head[NWHL*NSLT];
	int      tail[NWHL*NSLT];
	int      wpos[NWHL];

	function new();
		errors = 0;
		foreach (link[i]) begin
			link[i] = 0;
			remain[i] = 0;
			armed[i] = 0;
		end
		foreach (head[i]) begin
			head[i] = NTMR;
			tail[i] = 0;
		end
		foreach (wpos[i]) wpos[i] = 0;
	endfunction

	function longint span(int k);
		longint s;
		s = 1;
		for (int i = 0; i < k; i++) s = s * NSLT;
		return s;
	endfunction

	function bit place(int id, longint d);
		int     p;
		int     s;
		longint lo;
		for (int k = 0; k < NWHL; k++) begin
			lo = span(k);
			if (d < span(k + 1)) begin
				p = int'((wpos[k] + d / lo) % NSLT);
				s = k * NSLT + p;
				remain[id] = d % lo;
				armed[id] = 1;
				link[id] = NTMR;
				if (head[s] == NTMR) head[s] = id;
				else link[tail[s]] = id;
				tail[s] = id;
				return 1;
			end
		end
		return 0;
	endfunction

	function void push(htw_pkg::kind_t k, int id);
		expiry_t e;
		e.kind = k;
		e.id = id[5:0];
		e.last = 0;
		expiries.insert(expiries.size(), e);
	endfunction

	function void note(logic op, logic [5:0] id, logic [31:0] d);
		int  cur;
		int  nxt;
		int  n;
		int  lvl;
		int  s;
		bit  ok;
		if (op == htw_pkg::OP_ADD) begin
			ok = 0;
			if (!armed[id]) ok = place(id, longint'(d));
			push(ok ? htw_pkg::KIND_ADDED : htw_pkg::KIND_REJECTED, id);
			expiries[expiries.size()-1].last = 1;
			return;
		end
		s = wpos[0];
		cur = head[s];
		head[s] = NTMR;
		n = 0;
		while (cur < NTMR && n < NTMR) begin
			nxt = link[cur];
			armed[cur] = 0;
			push(htw_pkg::KIND_EXPIRED, cur);
			n++;
			cur = nxt;
		end
		if (n == 0) push(htw_pkg::KIND_NO_EXP, 0);
		expiries[expiries.size()-1].last = 1;
		// advance; a wrap pulls the next level's current slot down by remainder
		lvl = 0;
		forever begin
			wpos[lvl]++;
			if (wpos[lvl] < NSLT) break;
			wpos[lvl] = 0;
			lvl++;
			if (lvl >= NWHL) break;
			s = lvl * NSLT + wpos[lvl];
			cur = head[s];
			head[s] = NTMR;
			n = 0;
			while (cur < NTMR && n < NTMR) begin
				nxt = link[cur];
				armed[cur] = 0;
				void'(place(cur, remain[cur]));
				n++;
				cur = nxt;
			end
		end
	endfunction

	function void check(logic [1:0] k, logic [5:0] id, logic l);
		expiry_t e;
		if (expiries.size() == 0) begin
			$error("unexpected result kind %0d id %0d last %0d", k, id, l);
			errors++;
			return;
		end
		e = expiries[0];
		expiries.delete(0);
		if (k !== e.kind) begin
			$error("kind expected %0d actual %0d", e.kind, k);
			errors++;
		end
		if (id !== e.id) begin
			$error("expired_id expected %0d actual %0d", e.id, id);
			errors++;
		end
		if (l !== e.last) begin
			$error("last expected %0d actual %0d", e.last, l);
			errors++;
		end
	endfunction
endclass

module hierarchical_timer_wheel_test;
	localparam int LIMIT = 2000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        opcode = 0;
	logic [5:0]  timer_id = 0;
	logic [31:0] delay_ticks = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  kind;
	logic [5:0]  expired_id;
	logic        last;

	wheel_scoreboard board = new();
	bit quiet = 0;
	int cycles = 0;

	hierarchical_timer_wheel dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .timer_id(timer_id), .delay_ticks(delay_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .expired_id(expired_id), .last(last)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check(kind, expired_id, last);
		out_stall <= !quiet && ($urandom_range(99) < 15);
	end

	// one request; returns at the edge that accepts it
	task automatic send_request(logic op, logic [5:0] id, logic [31:0] d);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		opcode <= op;
		timer_id <= id;
		delay_ticks <= d;
		in_valid <= 1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		board.note(op, id, d);
	endtask

	task automatic add_timer(logic [5:0] id, logic [31:0] d);
		send_request(htw_pkg::OP_ADD, id, d);
	endtask

	task automatic tick();
		send_request(htw_pkg::OP_TICK, 6'd0, 32'd0);
	endtask

	initial begin
		int r;
		logic [31:0] d;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		tick();                           // empty slot
		add_timer(6'd0, 32'd0);
		tick();
		add_timer(6'd1, 32'd63);
		add_timer(6'd2, 32'd64);
		add_timer(6'd3, 32'd4095);
		add_timer(6'd4, 32'd4096);
		add_timer(6'd5, 32'hFF_FFFF);
		add_timer(6'd6, 32'h100_0000);    // just past top span
		add_timer(6'd7, 32'hFFFF_FFFF);
		add_timer(6'd1, 32'd5);           // already armed
		add_timer(6'd63, 32'd1);
		add_timer(6'd8, 32'd1);           // same slot, list order
		add_timer(6'd9, 32'h5555_5555);
		add_timer(6'd10, 32'hAAAA_AAAA);
		tick();
		tick();
		tick();

		for (int i = 0; i < 165; i++) begin
			quiet = (i >= 70 && i < 110);
			if ($urandom_range(99) < 55) tick();
			else begin
				r = $urandom_range(9);
				case (r)
					0, 1, 2, 3: d = $urandom_range(63);
					4, 5: d = $urandom_range(4095, 64);
					6: d = $urandom_range(32'hFF_FFFF, 4096);
					7: d = $urandom & 32'hFF_FFFF;
					default: d = $urandom;
				endcase
				add_timer(6'($urandom_range(63)), d);
			end
		end
		in_valid <= 0;
		quiet = 0;

		while (board.expiries.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
